// ===== rtl/core/ttce_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helpers for the text terminal cursor engine.
// Depends on nothing; used by ttce_step and text_terminal_cursor_engine.
package ttce_pkg;

  localparam int unsigned TabStop  = 8;
  localparam int unsigned MaxCmds  = 4;
  localparam int unsigned CmdIdxW  = $clog2(MaxCmds);
  localparam int unsigned CmdCntW  = $clog2(MaxCmds + 1);

  localparam logic [7:0] ResetColumns = 8'd80;
  localparam logic [7:0] ResetRows    = 8'd25;

  // Control bytes with a meaning of their own.
  localparam logic [7:0] ChBel = 8'h07;
  localparam logic [7:0] ChBs  = 8'h08;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChFf  = 8'h0C;
  localparam logic [7:0] ChCr  = 8'h0D;

  // Erase modes; any other value behaves as erase to end.
  localparam logic [7:0] EraseToStart = 8'd1;
  localparam logic [7:0] EraseAll     = 8'd2;

  typedef enum logic [2:0] {
    OP_CHAR         = 3'd0,
    OP_REL_MOVE     = 3'd1,
    OP_ABS_POS      = 3'd2,
    OP_COLUMN       = 3'd3,
    OP_ERASE_SCREEN = 3'd4,
    OP_ERASE_LINE   = 3'd5,
    OP_ERASE_CHARS  = 3'd6,
    OP_IGNORED      = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    CMD_PUT    = 3'd0,
    CMD_FILL   = 3'd1,
    CMD_COPY   = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_CURSOR = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    REG_COLUMNS = 2'd0,
    REG_ROWS    = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] out_char;
    logic [7:0] column;
    logic [7:0] row;
    logic [7:0] span;
    logic [7:0] source;
  } cmd_t;

  typedef struct packed {
    cmd_t [MaxCmds-1:0] cmds;
    logic [CmdCntW-1:0] count;
    logic [8:0]         cur_col;
    logic [7:0]         cur_row;
  } step_t;

  // Columns above 255 are reported as 255.
  function automatic logic [7:0] sat8(logic [8:0] v);
    return v[8] ? 8'hFF : v[7:0];
  endfunction

endpackage

// ===== rtl/core/text_terminal_cursor_engine.sv =====
`timescale 1ns / 1ps
// Top level of the text terminal cursor engine: cursor state, result buffer, registers.
// Depends on ttce_pkg and ttce_step.
//
// The engine takes parsed terminal tokens and turns each one into one to four draw
// commands for a text buffer, the last of which always reports the cursor and is marked
// by last_o. A token is decoded in the cycle in which its transaction is accepted: the
// cursor column and row are updated at once and all of its commands are written into a
// four-entry result buffer. The buffer then presents one command per cycle on the output
// channel while out_ready_i is high, and a token that yields k commands holds the buffer
// until all k are taken. k runs from 1 to 4: cursor moves and control characters that do
// not scroll give 1, a printable character gives 2, and a printable character that wraps
// and scrolls gives 4. The next token is accepted in the same cycle as the final command
// of the previous one is taken, so tokens flow at one per cycle when each yields a single
// command and the output is always ready. The screen size registers (index 0 columns,
// index 1 rows) are written through the configuration port, which is always ready; a value
// of zero acts as one. Writes to other indexes are accepted and ignored.
module text_terminal_cursor_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  // Token input
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        operation_i,
  input  logic [7:0]        char_code_i,
  input  logic signed [8:0] delta_x_i,
  input  logic signed [8:0] delta_y_i,
  input  logic [7:0]        column_param_i,
  input  logic [7:0]        row_param_i,
  input  logic [7:0]        erase_param_i,
  // Draw command output
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        command_o,
  output logic [7:0]        out_char_o,
  output logic [7:0]        target_column_o,
  output logic [7:0]        target_row_o,
  output logic [7:0]        span_count_o,
  output logic [7:0]        source_row_o,
  output logic              last_o
);
  import ttce_pkg::*;

  logic [7:0]           cols_q, rows_q;
  logic [8:0]           cur_col_q;
  logic [7:0]           cur_row_q;
  cmd_t [MaxCmds-1:0]   buf_q;
  logic [CmdCntW-1:0]   cnt_q;
  logic [CmdIdxW-1:0]   rd_q;
  step_t                step;
  logic                 in_acc, out_acc;
  cmd_t                 head;

  ttce_step u_step (
    .cols_i         (cols_q),
    .rows_i         (rows_q),
    .cur_col_i      (cur_col_q),
    .cur_row_i      (cur_row_q),
    .operation_i    (operation_i),
    .char_code_i    (char_code_i),
    .delta_x_i      (delta_x_i),
    .delta_y_i      (delta_y_i),
    .column_param_i (column_param_i),
    .row_param_i    (row_param_i),
    .erase_param_i  (erase_param_i),
    .step_o         (step)
  );

  // A new token may enter when the buffer is empty or its final command leaves now.
  assign in_ready_o  = (cnt_q == '0) || ((cnt_q == CmdCntW'(1)) && out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_acc     = out_valid_o && out_ready_i;
  assign cfg_ready_o = 1'b1;

  assign head            = buf_q[rd_q];
  assign command_o       = head.command;
  assign out_char_o      = head.out_char;
  assign target_column_o = head.column;
  assign target_row_o    = head.row;
  assign span_count_o    = head.span;
  assign source_row_o    = head.source;
  assign last_o          = (cnt_q == CmdCntW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q    <= ResetColumns;
      rows_q    <= ResetRows;
      cur_col_q <= '0;
      cur_row_q <= '0;
      cnt_q     <= '0;
      rd_q      <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_COLUMNS: cols_q <= cfg_data_i;
          REG_ROWS:    rows_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        cur_col_q <= step.cur_col;
        cur_row_q <= step.cur_row;
        cnt_q     <= step.count;
        rd_q      <= '0;
      end else if (out_acc) begin
        cnt_q <= cnt_q - CmdCntW'(1);
        rd_q  <= rd_q + CmdIdxW'(1);
      end
    end
  end

  // The command buffer carries payload only and needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      buf_q <= step.cmds;
    end
  end

endmodule

// ===== rtl/core/ttce_step.sv =====
`timescale 1ns / 1ps
// Combinational token decoder: builds the draw commands and the next cursor.
// Depends on ttce_pkg.
module ttce_step (
  input  logic [7:0]         cols_i,
  input  logic [7:0]         rows_i,
  input  logic [8:0]         cur_col_i,
  input  logic [7:0]         cur_row_i,
  input  logic [2:0]         operation_i,
  input  logic [7:0]         char_code_i,
  input  logic signed [8:0]  delta_x_i,
  input  logic signed [8:0]  delta_y_i,
  input  logic [7:0]         column_param_i,
  input  logic [7:0]         row_param_i,
  input  logic [7:0]         erase_param_i,
  output ttce_pkg::step_t    step_o
);
  import ttce_pkg::*;

  function automatic cmd_t mk(cmd_e c, logic [7:0] ch, logic [7:0] col, logic [7:0] row,
                              logic [7:0] span, logic [7:0] src);
    cmd_t r;
    r.command  = c;
    r.out_char = ch;
    r.column   = col;
    r.row      = row;
    r.span     = span;
    r.source   = src;
    return r;
  endfunction

  // Clamp a signed position to 0 .. lim-1.
  function automatic logic [7:0] clamp_pos(logic signed [10:0] v, logic [7:0] lim);
    if (v[10]) begin
      return 8'd0;
    end else if (v[9:0] >= {2'b00, lim}) begin
      return lim - 8'd1;
    end else begin
      return v[7:0];
    end
  endfunction

  logic [7:0]           w, h;
  logic [8:0]           y, d;
  logic [7:0]           d8;
  logic                 scroll;
  logic [7:0]           adv_row;
  cmd_t                 copy_cmd, scroll_clr_cmd;
  logic [7:0]           room, to_cursor, rows_above, rows_below, colp_m1, rowp_m1, fcnt;
  logic [9:0]           tab_col;
  logic signed [10:0]   sx, sy;
  cmd_t [MaxCmds-1:0]   slots;
  logic [CmdCntW-1:0]   n;
  logic [8:0]           col;
  logic [7:0]           row;

  always_comb begin
    w = (cols_i == 8'd0) ? 8'd1 : cols_i;
    h = (rows_i == 8'd0) ? 8'd1 : rows_i;

    // Row advance from the current row, with a scroll at the bottom.
    y      = {1'b0, cur_row_i} + 9'd1;
    scroll = (y >= {1'b0, h});
    d      = y - {1'b0, h} + 9'd1;
    d8     = (d > {1'b0, h}) ? h : d[7:0];
    adv_row = scroll ? (h - 8'd1) : y[7:0];
    copy_cmd       = mk(CMD_COPY, 8'd0, 8'd0, 8'd0, h - d8, d8);
    scroll_clr_cmd = mk(CMD_CLEAR, 8'd0, 8'd0, h - d8, d8, 8'd0);

    room       = (cur_col_i < {1'b0, w}) ? (w - cur_col_i[7:0]) : 8'd0;
    to_cursor  = (cur_col_i < {1'b0, w}) ? cur_col_i[7:0] : w;
    rows_above = (cur_row_i < h) ? cur_row_i : h;
    rows_below = ({1'b0, cur_row_i} + 9'd1 < {1'b0, h}) ? (h - cur_row_i - 8'd1) : 8'd0;
    colp_m1    = (column_param_i == 8'd0) ? 8'd0 : (column_param_i - 8'd1);
    rowp_m1    = (row_param_i == 8'd0) ? 8'd0 : (row_param_i - 8'd1);
    sx = $signed({2'b00, cur_col_i}) + $signed({{2{delta_x_i[8]}}, delta_x_i});
    sy = $signed({3'b000, cur_row_i}) + $signed({{2{delta_y_i[8]}}, delta_y_i});
    tab_col = {1'b0, cur_col_i} + 10'(TabStop) - 10'(cur_col_i % TabStop);
    fcnt = 8'd0;

    slots = '0;
    n     = '0;
    col   = cur_col_i;
    row   = cur_row_i;

    unique case (op_e'(operation_i))
      OP_CHAR: begin
        unique case (char_code_i)
          ChBel: begin
          end
          ChLf, ChFf: begin
            col = 9'd0;
            if (scroll) begin
              slots[n[CmdIdxW-1:0]] = copy_cmd;
              n = n + 1'b1;
              slots[n[CmdIdxW-1:0]] = scroll_clr_cmd;
              n = n + 1'b1;
            end
            row = adv_row;
          end
          ChCr: begin
            col = 9'd0;
          end
          ChTab: begin
            if (tab_col >= {2'b00, w}) begin
              if (scroll) begin
                slots[n[CmdIdxW-1:0]] = copy_cmd;
                n = n + 1'b1;
                slots[n[CmdIdxW-1:0]] = scroll_clr_cmd;
                n = n + 1'b1;
              end
              row = adv_row;
              tab_col = tab_col - {2'b00, w};
            end
            col = tab_col[8:0];
          end
          ChBs: begin
            if (cur_col_i != 9'd0) begin
              col = cur_col_i - 9'd1;
            end
          end
          default: begin
            // Pending wrap is resolved before the character is placed.
            if (cur_col_i >= {1'b0, w}) begin
              col = 9'd0;
              if (scroll) begin
                slots[n[CmdIdxW-1:0]] = copy_cmd;
                n = n + 1'b1;
                slots[n[CmdIdxW-1:0]] = scroll_clr_cmd;
                n = n + 1'b1;
              end
              row = adv_row;
            end
            slots[n[CmdIdxW-1:0]] = mk(CMD_PUT, char_code_i, sat8(col), row, 8'd0, 8'd0);
            n = n + 1'b1;
            col = col + 9'd1;
          end
        endcase
      end
      OP_REL_MOVE: begin
        col = {1'b0, clamp_pos(sx, w)};
        row = clamp_pos(sy, h);
      end
      OP_ABS_POS: begin
        col = {1'b0, clamp_pos($signed({3'b000, colp_m1}), w)};
        row = clamp_pos($signed({3'b000, rowp_m1}), h);
      end
      OP_COLUMN: begin
        col = {1'b0, clamp_pos($signed({3'b000, colp_m1}), w)};
        row = clamp_pos($signed({3'b000, cur_row_i}), h);
      end
      OP_ERASE_SCREEN: begin
        if (erase_param_i == EraseAll) begin
          slots[n[CmdIdxW-1:0]] = mk(CMD_CLEAR, 8'd0, 8'd0, 8'd0, h, 8'd0);
          n = n + 1'b1;
        end else if (erase_param_i == EraseToStart) begin
          if (to_cursor != 8'd0) begin
            slots[n[CmdIdxW-1:0]] = mk(CMD_FILL, 8'd0, 8'd0, cur_row_i, to_cursor, 8'd0);
            n = n + 1'b1;
          end
          slots[n[CmdIdxW-1:0]] = mk(CMD_CLEAR, 8'd0, 8'd0, 8'd0, rows_above, 8'd0);
          n = n + 1'b1;
        end else begin
          if (room != 8'd0) begin
            slots[n[CmdIdxW-1:0]] = mk(CMD_FILL, 8'd0, sat8(cur_col_i), cur_row_i, room, 8'd0);
            n = n + 1'b1;
          end
          slots[n[CmdIdxW-1:0]] = mk(CMD_CLEAR, 8'd0, 8'd0, sat8(y), rows_below, 8'd0);
          n = n + 1'b1;
        end
      end
      OP_ERASE_LINE: begin
        if (erase_param_i == EraseAll) begin
          slots[n[CmdIdxW-1:0]] = mk(CMD_CLEAR, 8'd0, 8'd0, cur_row_i, 8'd1, 8'd0);
          n = n + 1'b1;
        end else if (erase_param_i == EraseToStart) begin
          if (to_cursor != 8'd0) begin
            slots[n[CmdIdxW-1:0]] = mk(CMD_FILL, 8'd0, 8'd0, cur_row_i, to_cursor, 8'd0);
            n = n + 1'b1;
          end
        end else begin
          if (room != 8'd0) begin
            slots[n[CmdIdxW-1:0]] = mk(CMD_FILL, 8'd0, sat8(cur_col_i), cur_row_i, room, 8'd0);
            n = n + 1'b1;
          end
        end
      end
      OP_ERASE_CHARS: begin
        fcnt = (erase_param_i < room) ? erase_param_i : room;
        if (fcnt != 8'd0) begin
          slots[n[CmdIdxW-1:0]] = mk(CMD_FILL, 8'd0, sat8(cur_col_i), cur_row_i, fcnt, 8'd0);
          n = n + 1'b1;
        end
      end
      OP_IGNORED: begin
      end
    endcase

    // Every token ends by reporting the cursor.
    slots[n[CmdIdxW-1:0]] = mk(CMD_CURSOR, 8'd0, sat8(col), row, 8'd0, 8'd0);
    n = n + 1'b1;

    step_o.cmds    = slots;
    step_o.count   = n;
    step_o.cur_col = col;
    step_o.cur_row = row;
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the text terminal cursor engine. A scoreboard class works
// out the draw commands of every token and checks them; plain tasks drive the channels.
// Depends on ttce_pkg and text_terminal_cursor_engine.
module tb_top;
  import ttce_pkg::*;

  // One token as offered on the input channel.
  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
    logic [8:0] dx;
    logic [8:0] dy;
    logic [7:0] colp;
    logic [7:0] rowp;
    logic [7:0] ep;
  } token_t;

  // One draw command as seen on the output channel.
  typedef struct packed {
    cmd_e       command;
    logic [7:0] ch;
    logic [7:0] column;
    logic [7:0] row;
    logic [7:0] span;
    logic [7:0] src;
    logic       last;
  } draw_cmd_t;

  // The scoreboard keeps its own copy of the cursor and of the screen size. Each accepted
  // token is turned into the draw commands it must cause, and each accepted command is
  // checked against the oldest of those still waiting.
  class draw_scoreboard;
    int        columns;
    int        rows;
    int        cur_col;
    int        cur_row;
    int        failures;
    draw_cmd_t expected_cmds[$];

    function new();
      columns  = ResetColumns;
      rows     = ResetRows;
      cur_col  = 0;
      cur_row  = 0;
      failures = 0;
    endfunction

    function void set_register(cfg_reg_e idx, logic [7:0] value);
      if (idx == REG_COLUMNS) begin
        columns = value;
      end else if (idx == REG_ROWS) begin
        rows = value;
      end
    endfunction

    function logic [7:0] clip_byte(int v);
      return (v > 255) ? 8'hFF : 8'(v);
    endfunction

    function void push_cmd(cmd_e c, int ch, int col, int row, int span, int src,
                           bit is_last);
      draw_cmd_t d;
      d.command = c;
      d.ch      = 8'(ch);
      d.column  = clip_byte(col);
      d.row     = clip_byte(row);
      d.span    = clip_byte(span);
      d.src     = clip_byte(src);
      d.last    = is_last;
      expected_cmds.push_back(d);
    endfunction

    // Moves the cursor down one row. At the bottom the screen scrolls; if the cursor sat
    // further below the bottom (the row register was lowered), the scroll distance is
    // limited to the height of the screen.
    function void advance_row();
      int h;
      int y;
      int d;
      h = (rows == 0) ? 1 : rows;
      y = cur_row + 1;
      if (y >= h) begin
        d = y - h + 1;
        if (d > h) begin
          d = h;
        end
        push_cmd(CMD_COPY, 0, 0, 0, h - d, d, 1'b0);
        push_cmd(CMD_CLEAR, 0, 0, h - d, d, 0, 1'b0);
        y = h - 1;
      end
      cur_row = y & 'hFF;
    endfunction

    // A fill of no cells gives no command at all.
    function void fill_span(int col, int count);
      if (count != 0) begin
        push_cmd(CMD_FILL, 0, col, cur_row, count, 0, 1'b0);
      end
    endfunction

    function int room_to_end(int w);
      return (cur_col < w) ? w - cur_col : 0;
    endfunction

    function int clamp_to(int v, int limit);
      if (v < 0) begin
        return 0;
      end
      if (v >= limit) begin
        return limit - 1;
      end
      return v;
    endfunction

    function void predict_commands(token_t t);
      int w;
      int h;
      int c;
      w = (columns == 0) ? 1 : columns;
      h = (rows == 0) ? 1 : rows;
      case (t.op)
        OP_CHAR: begin
          case (t.ch)
            ChBel: ;
            ChLf, ChFf: begin
              cur_col = 0;
              advance_row();
            end
            ChCr: cur_col = 0;
            ChTab: begin
              cur_col += int'(TabStop) - cur_col % int'(TabStop);
              if (cur_col >= w) begin
                advance_row();
                cur_col -= w;
              end
              cur_col &= 'h1FF;
            end
            ChBs: begin
              if (cur_col != 0) begin
                cur_col--;
              end
            end
            default: begin
              // A pending wrap is taken before the character is put.
              if (cur_col >= w) begin
                cur_col = 0;
                advance_row();
              end
              push_cmd(CMD_PUT, t.ch, cur_col, cur_row, 0, 0, 1'b0);
              cur_col = (cur_col + 1) & 'h1FF;
            end
          endcase
        end
        OP_REL_MOVE: begin
          cur_col = clamp_to(cur_col + int'($signed(t.dx)), w);
          cur_row = clamp_to(cur_row + int'($signed(t.dy)), h);
        end
        OP_ABS_POS: begin
          cur_col = clamp_to((t.colp == 0) ? 0 : int'(t.colp) - 1, w);
          cur_row = clamp_to((t.rowp == 0) ? 0 : int'(t.rowp) - 1, h);
        end
        OP_COLUMN: begin
          cur_col = clamp_to((t.colp == 0) ? 0 : int'(t.colp) - 1, w);
          cur_row = clamp_to(cur_row, h);
        end
        OP_ERASE_SCREEN: begin
          if (t.ep == EraseAll) begin
            push_cmd(CMD_CLEAR, 0, 0, 0, h, 0, 1'b0);
          end else if (t.ep == EraseToStart) begin
            fill_span(0, (cur_col < w) ? cur_col : w);
            push_cmd(CMD_CLEAR, 0, 0, 0, (cur_row < h) ? cur_row : h, 0, 1'b0);
          end else begin
            fill_span(cur_col, room_to_end(w));
            c = (cur_row + 1 < h) ? h - cur_row - 1 : 0;
            push_cmd(CMD_CLEAR, 0, 0, cur_row + 1, c, 0, 1'b0);
          end
        end
        OP_ERASE_LINE: begin
          if (t.ep == EraseAll) begin
            push_cmd(CMD_CLEAR, 0, 0, cur_row, 1, 0, 1'b0);
          end else if (t.ep == EraseToStart) begin
            fill_span(0, (cur_col < w) ? cur_col : w);
          end else begin
            fill_span(cur_col, room_to_end(w));
          end
        end
        OP_ERASE_CHARS: begin
          c = room_to_end(w);
          fill_span(cur_col, (int'(t.ep) < c) ? int'(t.ep) : c);
        end
        default: ;
      endcase
      // Every token finishes by reporting the cursor.
      push_cmd(CMD_CURSOR, 0, cur_col, cur_row, 0, 0, 1'b1);
    endfunction

    function string describe(draw_cmd_t d);
      return $sformatf("cmd=%0d char=%02h col=%0d row=%0d span=%0d src=%0d last=%0b",
                       d.command, d.ch, d.column, d.row, d.span, d.src, d.last);
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function void check_command(draw_cmd_t got);
      draw_cmd_t want;
      if (expected_cmds.size() == 0) begin
        report($sformatf("Unexpected draw command: %s", describe(got)));
        return;
      end
      want = expected_cmds.pop_front();
      if (got.command !== want.command || got.ch !== want.ch ||
          got.column !== want.column || got.row !== want.row ||
          got.span !== want.span || got.src !== want.src || got.last !== want.last) begin
        report($sformatf("Draw command mismatch: expected %s, got %s",
                         describe(want), describe(got)));
      end
    endfunction
  endclass

  // All inputs of the engine start at known values.
  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data  = '0;
  logic       in_valid  = 1'b0;
  logic [2:0] operation = '0;
  logic [7:0] char_code = '0;
  logic [8:0] delta_x   = '0;
  logic [8:0] delta_y   = '0;
  logic [7:0] col_param = '0;
  logic [7:0] row_param = '0;
  logic [7:0] erase_par = '0;
  logic       out_ready = 1'b0;

  logic       cfg_ready;
  logic       in_ready;
  logic       out_valid;
  logic [2:0] command;
  logic [7:0] out_char;
  logic [7:0] target_column;
  logic [7:0] target_row;
  logic [7:0] span_count;
  logic [7:0] source_row;
  logic       last;

  draw_scoreboard sb;
  draw_cmd_t      seen_cmd;

  // Receiver state: the long hold-off is requested by the stimulus and counted here.
  bit hold_off_go = 1'b0;
  bit hold_done   = 1'b0;
  int hold_left   = 0;
  int rx_cycle    = 0;

  text_terminal_cursor_engine u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .operation_i     (operation),
    .char_code_i     (char_code),
    .delta_x_i       (delta_x),
    .delta_y_i       (delta_y),
    .column_param_i  (col_param),
    .row_param_i     (row_param),
    .erase_param_i   (erase_par),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .command_o       (command),
    .out_char_o      (out_char),
    .target_column_o (target_column),
    .target_row_o    (target_row),
    .span_count_o    (span_count),
    .source_row_o    (source_row),
    .last_o          (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Writes both screen size registers in two back-to-back transactions. The scoreboard
  // takes each value at the edge where its transaction completes. Only called while the
  // engine has nothing outstanding.
  task automatic configure_screen(logic [7:0] cols, logic [7:0] rws);
    cfg_valid <= 1'b1;
    cfg_index <= REG_COLUMNS;
    cfg_data  <= cols;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(REG_COLUMNS, cols);
    cfg_index <= REG_ROWS;
    cfg_data  <= rws;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(REG_ROWS, rws);
    cfg_valid <= 1'b0;
  endtask

  // Offers one token and returns at the edge where it is accepted, with valid still
  // high, so that a following token can be offered without a gap.
  task automatic offer_token(token_t t);
    in_valid  <= 1'b1;
    operation <= t.op;
    char_code <= t.ch;
    delta_x   <= t.dx;
    delta_y   <= t.dy;
    col_param <= t.colp;
    row_param <= t.rowp;
    erase_par <= t.ep;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.predict_commands(t);
  endtask

  task automatic pause_sender(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Waits until every expected draw command has been taken.
  task automatic drain_engine();
    in_valid <= 1'b0;
    while (sb.expected_cmds.size() != 0) @(posedge clk);
  endtask

  // Builds a token of the given kind: the fields that matter for it come from a and b,
  // all other fields carry random bits, which the engine has to ignore.
  function automatic token_t shaped_token(op_e op, int a, int b);
    token_t t;
    t.op   = op;
    t.ch   = 8'($urandom);
    t.dx   = 9'($urandom);
    t.dy   = 9'($urandom);
    t.colp = 8'($urandom);
    t.rowp = 8'($urandom);
    t.ep   = 8'($urandom);
    case (op)
      OP_CHAR:     t.ch = a[7:0];
      OP_REL_MOVE: begin
        t.dx = a[8:0];
        t.dy = b[8:0];
      end
      OP_ABS_POS:  begin
        t.colp = a[7:0];
        t.rowp = b[7:0];
      end
      OP_COLUMN:   t.colp = a[7:0];
      OP_ERASE_SCREEN, OP_ERASE_LINE, OP_ERASE_CHARS: t.ep = a[7:0];
      default: ;
    endcase
    return t;
  endfunction

  task automatic offer_shaped(op_e op, int a, int b);
    offer_token(shaped_token(op, a, b));
    pause_sender($urandom_range(0, 2));
  endtask

  // Random tokens, weighted towards characters so that wraps and scrolls happen often.
  // Parameters mostly stay near the screen so that moves land inside it, with a share of
  // full-range values for the clamping paths.
  function automatic token_t random_token();
    int pick;
    int a;
    int b;
    op_e op;
    pick = $urandom_range(0, 99);
    a = 0;
    b = 0;
    if (pick < 50) begin
      op = OP_CHAR;
      if ($urandom_range(0, 9) < 4) begin
        case ($urandom_range(0, 5))
          0: a = ChLf;
          1: a = ChFf;
          2: a = ChCr;
          3: a = ChTab;
          4: a = ChBs;
          default: a = ChBel;
        endcase
      end else begin
        a = $urandom_range(0, 255);
      end
    end else if (pick < 62) begin
      op = OP_REL_MOVE;
      a = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 511)) - 256
                                      : int'($urandom_range(0, 6)) - 3;
      b = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 511)) - 256
                                      : int'($urandom_range(0, 6)) - 3;
    end else if (pick < 70) begin
      op = OP_ABS_POS;
      a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
      b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
    end else if (pick < 76) begin
      op = OP_COLUMN;
      a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
    end else if (pick < 84) begin
      op = OP_ERASE_SCREEN;
      a = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 2);
    end else if (pick < 90) begin
      op = OP_ERASE_LINE;
      a = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 2);
    end else if (pick < 97) begin
      op = OP_ERASE_CHARS;
      a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
    end else begin
      op = OP_IGNORED;
    end
    return shaped_token(op, a, b);
  endfunction

  // The sender works in bursts of random length; the gap after a burst is often zero, so
  // long stretches of back-to-back tokens occur as well.
  task automatic run_random(int n_items);
    int left;
    int burst;
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && left > 0) begin
        offer_token(random_token());
        burst--;
        left--;
      end
      pause_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
    end
  endtask

  // Receiver: takes draw commands and checks them at the edge of each transaction. Its
  // ready follows a pattern of its own, set by a free-running cycle count, that ranges from
  // always ready to mostly stalled, and once it holds off for a long stretch so that the
  // result buffer fills up and the engine stalls its input.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen_cmd.command = cmd_e'(command);
        seen_cmd.ch      = out_char;
        seen_cmd.column  = target_column;
        seen_cmd.row     = target_row;
        seen_cmd.span    = span_count;
        seen_cmd.src     = source_row;
        seen_cmd.last    = last;
        sb.check_command(seen_cmd);
      end
      rx_cycle++;
      if (hold_off_go && !hold_done) begin
        hold_left = 90;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case ((rx_cycle / 40) % 4)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (rx_cycle % 3 != 0);
        endcase
      end
    end
  end

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on a small screen of ten columns and four rows, where tabs wrap and
    // the bottom is reached quickly.
    configure_screen(8'd10, 8'd4);
    offer_shaped(OP_CHAR, 'h41, 0);
    offer_shaped(OP_CHAR, ChBel, 0);
    offer_shaped(OP_CHAR, ChTab, 0);
    offer_shaped(OP_CHAR, ChTab, 0);               // tab past the right edge wraps
    offer_shaped(OP_CHAR, ChBs, 0);
    offer_shaped(OP_CHAR, ChCr, 0);
    offer_shaped(OP_CHAR, ChLf, 0);
    offer_shaped(OP_CHAR, ChFf, 0);
    offer_shaped(OP_REL_MOVE, 255, 255);           // clamps to the bottom right corner
    offer_shaped(OP_CHAR, 'h00, 0);                // leaves a wrap pending
    offer_shaped(OP_CHAR, 'hFF, 0);                // wraps and scrolls: four commands
    offer_shaped(OP_REL_MOVE, -256, -256);         // negative target clamps to zero
    offer_shaped(OP_ABS_POS, 0, 0);                // zero parameters are taken as one
    offer_shaped(OP_ABS_POS, 255, 255);
    offer_shaped(OP_COLUMN, 5, 0);
    offer_shaped(OP_ERASE_SCREEN, 0, 0);
    offer_shaped(OP_ERASE_SCREEN, EraseToStart, 0);
    offer_shaped(OP_ERASE_SCREEN, EraseAll, 0);
    offer_shaped(OP_ERASE_SCREEN, 255, 0);         // unknown mode acts as erase to end
    offer_shaped(OP_ERASE_LINE, 0, 0);
    offer_shaped(OP_ERASE_LINE, EraseToStart, 0);
    offer_shaped(OP_ERASE_LINE, EraseAll, 0);
    offer_shaped(OP_ERASE_CHARS, 255, 0);          // clipped at the line end
    offer_shaped(OP_ERASE_CHARS, 0, 0);            // empty fill gives no command
    offer_shaped(OP_IGNORED, 0, 0);
    drain_engine();

    // Random phases over several screen sizes, the extremes among them.
    configure_screen(8'd80, 8'd25);
    run_random(35);
    drain_engine();

    configure_screen(8'd1, 8'd1);
    run_random(20);
    drain_engine();

    configure_screen(8'd0, 8'd0);                  // zero registers behave as one
    run_random(15);
    drain_engine();

    configure_screen(8'd255, 8'd255);
    run_random(30);
    offer_shaped(OP_ABS_POS, 201, 201);            // park the cursor far out
    drain_engine();

    // Shrinking the screen leaves the cursor beyond both edges, so the next row advance
    // has to limit its scroll distance to the screen height.
    configure_screen(8'd7, 8'd3);
    offer_shaped(OP_CHAR, ChTab, 0);
    run_random(35);
    drain_engine();

    // Last phase: the receiver holds off for a long stretch while the sender keeps
    // offering tokens back to back.
    configure_screen(8'd16, 8'd8);
    hold_off_go = 1'b1;
    repeat (12) offer_token(random_token());
    run_random(33);
    drain_engine();

    // Allow a few more cycles so that any stray command is caught.
    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.expected_cmds.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake: 2 ms is far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ttce_pkg.sv
rtl/core/ttce_step.sv
rtl/core/text_terminal_cursor_engine.sv
sim/tb_top.sv
